@@ rtl/core/htep_pkg.sv @@
// ----------------------------------------------------------------------------
// htep_pkg
// Shared types and constants for the table-driven prefix-code encoder and
// bit packer.
// ----------------------------------------------------------------------------
package htep_pkg;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 15;
  localparam int LEN_W    = 4;
  localparam int USED_W   = 4;
  localparam int PEND_W   = BYTE_W - 1;
  localparam int PCNT_W   = 3;
  // Bit count after an append: at most 7 + 15 = 22
  localparam int CNT_W    = 5;
  localparam int TBL_DEPTH = 256;

  // Result queue
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = 3;
  localparam int QCNT_W   = 4;

  // Function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  // Status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  // Input request
  typedef struct packed {
    logic [1:0]        func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    logic              entry_present;
  } sym_req_t;

  // Output result
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [USED_W-1:0] bits_used;
    logic              status;
    logic              last_of_run;
  } byte_res_t;

endpackage

@@ rtl/core/huffman_table_encoder_packer_unit.sv @@
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer_unit
// Table-driven prefix-code encoder with an MSB-first byte packer.
// ----------------------------------------------------------------------------
// Usage:
//   sym channel (sym_valid / sym_stall / sym_data) takes requests: load a
//   code table entry, encode one byte symbol, or flush the held bits.
//   byte channel (byte_valid / byte_stall / byte_data) returns packed bytes,
//   flush remainders (right-aligned, upper bits zero) and absent-symbol
//   errors. last_of_run marks the final result of each request.
// Path: a request's table read is registered in the read stage, then its
//   results are appended, packed and written into the result queue.
// Throughput: one request per cycle while sym_stall is low. The code table
//   is a 256-entry memory with one write and one registered read per cycle;
//   a load writes at its accept edge, so an encode in the next cycle sees it.
//   A request makes up to two results and the byte port drains one per cycle
//   while not stalled, so a long run of two-byte codes is paced by that port.
// Reset: rst clears the per-entry valid flags (all symbols absent), the
//   held bits and the result queue; no clearing pass.
// Stall: results wait in an 8-entry queue; sym_stall rises when the queue
//   cannot take the worst case of two results per request in flight.
// ----------------------------------------------------------------------------
module huffman_table_encoder_packer_unit #(
  parameter int MAX_CODE_LEN = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sym_valid,
  output logic                 sym_stall,
  input  htep_pkg::sym_req_t   sym_data,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output htep_pkg::byte_res_t  byte_data
);

  localparam int BYTE_W  = htep_pkg::BYTE_W;
  localparam int LEN_W   = htep_pkg::LEN_W;
  localparam int CNT_W   = htep_pkg::CNT_W;
  localparam int PEND_W  = htep_pkg::PEND_W;
  localparam int PCNT_W  = htep_pkg::PCNT_W;
  localparam int ENTRY_W = 1 + LEN_W + MAX_CODE_LEN;
  localparam int ACC_W   = PEND_W + MAX_CODE_LEN;
  localparam int QDEPTH  = htep_pkg::QDEPTH;
  localparam int QPTR_W  = htep_pkg::QPTR_W;
  localparam int QCNT_W  = htep_pkg::QCNT_W;

  // Stored entry: present flag, length, code
  typedef struct packed {
    logic                    present;
    logic [LEN_W-1:0]        len;
    logic [MAX_CODE_LEN-1:0] bits;
  } entry_t;

  // Code table memory and per-entry written flags
  logic [ENTRY_W-1:0]             table_mem [htep_pkg::TBL_DEPTH];
  logic [htep_pkg::TBL_DEPTH-1:0] entry_written;

  // Read stage registers
  logic       s1_valid;
  logic [1:0] s1_func;
  entry_t     s1_entry;
  logic       s1_written;

  // Packer state
  logic [PEND_W-1:0] pend_bits;
  logic [PEND_W-1:0] pend_bits_next;
  logic [PCNT_W-1:0] pend_cnt;
  logic [PCNT_W-1:0] pend_cnt_next;

  // Result queue
  htep_pkg::byte_res_t q_mem [QDEPTH];
  logic [QPTR_W-1:0]   q_wr;
  logic [QPTR_W-1:0]   q_rd;
  logic [QCNT_W-1:0]   q_cnt;

  logic                sym_accept;
  logic                byte_pop;
  logic [1:0]          n_push;
  htep_pkg::byte_res_t res0;
  htep_pkg::byte_res_t res1;
  logic [LEN_W-1:0]    load_len;

  // Packer datapath
  logic [ACC_W-1:0] code_mask;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rem_mask;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_rem;
  logic [CNT_W-1:0] shift0;
  logic [CNT_W-1:0] shift1;
  logic             e_present;

  // Backpressure: queue must hold the worst case from both requests in flight
  always_comb begin
    sym_stall = rst ||
      ((QCNT_W+2)'(q_cnt) + (s1_valid ? (QCNT_W+2)'(2) : '0) + (QCNT_W+2)'(2)
        > (QCNT_W+2)'(QDEPTH));
  end

  assign sym_accept = sym_valid && !sym_stall;
  assign byte_pop   = byte_valid && !byte_stall;

  // Saturate overlong lengths on load
  assign load_len = (sym_data.code_len > LEN_W'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : sym_data.code_len;

  // Table write on load, registered read every cycle
  always_ff @(posedge clk) begin
    if (sym_accept && sym_data.func == htep_pkg::FUNC_LOAD) begin
      table_mem[sym_data.symbol] <= {sym_data.entry_present, load_len,
                                     sym_data.code_bits[MAX_CODE_LEN-1:0]};
    end
    s1_entry   <= entry_t'(table_mem[sym_data.symbol]);
    s1_written <= entry_written[sym_data.symbol];
    s1_func    <= sym_data.func;
  end

  // Written flags and read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_written <= '0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= sym_accept;
      if (sym_accept && sym_data.func == htep_pkg::FUNC_LOAD) begin
        entry_written[sym_data.symbol] <= 1'b1;
      end
    end
  end

  // Append code to held bits and cut out full bytes
  assign e_present = s1_written && s1_entry.present;
  assign code_mask = (ACC_W'(1) << s1_entry.len) - ACC_W'(1);
  assign acc       = (ACC_W'(pend_bits) << s1_entry.len) |
                     (ACC_W'(s1_entry.bits) & code_mask);
  assign cnt       = CNT_W'(pend_cnt) + CNT_W'(s1_entry.len);
  assign shift0    = cnt - CNT_W'(BYTE_W);
  assign shift1    = cnt - CNT_W'(2 * BYTE_W);
  assign cnt_rem   = (cnt >= CNT_W'(2 * BYTE_W)) ? shift1 :
                     (cnt >= CNT_W'(BYTE_W))     ? shift0 : cnt;
  assign rem_mask  = (ACC_W'(1) << cnt_rem) - ACC_W'(1);

  // Result selection per request kind
  always_comb begin
    n_push         = 2'd0;
    res0           = '0;
    res1           = '0;
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    if (s1_valid) begin
      case (s1_func)
        htep_pkg::FUNC_ENCODE: begin
          if (!e_present) begin
            n_push           = 2'd1;
            res0.status      = htep_pkg::STATUS_ABSENT;
            res0.last_of_run = 1'b1;
          end else if (s1_entry.len != '0) begin
            pend_bits_next = PEND_W'(acc & rem_mask);
            pend_cnt_next  = PCNT_W'(cnt_rem);
            res0.out_byte  = BYTE_W'(acc >> shift0);
            res0.bits_used = htep_pkg::USED_W'(BYTE_W);
            res0.status    = htep_pkg::STATUS_OK;
            res1.out_byte  = BYTE_W'(acc >> shift1);
            res1.bits_used = htep_pkg::USED_W'(BYTE_W);
            res1.status    = htep_pkg::STATUS_OK;
            if (cnt >= CNT_W'(2 * BYTE_W)) begin
              n_push           = 2'd2;
              res1.last_of_run = 1'b1;
            end else if (cnt >= CNT_W'(BYTE_W)) begin
              n_push           = 2'd1;
              res0.last_of_run = 1'b1;
            end
          end
        end
        htep_pkg::FUNC_FLUSH: begin
          if (pend_cnt != '0) begin
            n_push           = 2'd1;
            res0.out_byte    = BYTE_W'(pend_bits);
            res0.bits_used   = htep_pkg::USED_W'(pend_cnt);
            res0.status      = htep_pkg::STATUS_OK;
            res0.last_of_run = 1'b1;
            pend_bits_next   = '0;
            pend_cnt_next    = '0;
          end
        end
        default: begin
          n_push = 2'd0;
        end
      endcase
    end
  end

  // Packer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[q_wr] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem[q_wr + QPTR_W'(1)] <= res1;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      q_wr  <= q_wr + QPTR_W'(n_push);
      q_rd  <= q_rd + QPTR_W'(byte_pop);
      q_cnt <= q_cnt + QCNT_W'(n_push) - QCNT_W'(byte_pop);
    end
  end

  assign byte_valid = (q_cnt != '0);
  assign byte_data  = q_mem[q_rd];

endmodule

@@ rtl/core/htep_checker.sv @@
// ----------------------------------------------------------------------------
// htep_checker
// Port-level checks for the encoder and packer, bound to the top level.
// ----------------------------------------------------------------------------
module htep_checker (
  input logic                clk,
  input logic                rst,
  input logic                sym_stall,
  input logic                byte_valid,
  input logic                byte_stall,
  input htep_pkg::byte_res_t byte_data
);

  // Nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !byte_valid)
    else $error("result shown right after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
    else $error("stalled result changed");

  // Absent-symbol error has no data and ends its request
  a_absent: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_data.status == htep_pkg::STATUS_ABSENT |->
      byte_data.out_byte == '0 && byte_data.bits_used == '0 &&
      byte_data.last_of_run)
    else $error("malformed absent-symbol result");

  // A partial byte is a flush remainder: last of run, nonzero, top bit zero
  a_partial: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_data.status == htep_pkg::STATUS_OK &&
    byte_data.bits_used != 4'd8 |->
      byte_data.last_of_run && byte_data.bits_used != '0 &&
      byte_data.bits_used < 4'd8 && !byte_data.out_byte[7])
    else $error("malformed partial byte");

  // No request is taken while in reset
  a_rst_stall: assert property (@(posedge clk) rst |-> sym_stall)
    else $error("request taken during reset");

endmodule

bind huffman_table_encoder_packer_unit htep_checker u_htep_checker (
  .clk        (clk),
  .rst        (rst),
  .sym_stall  (sym_stall),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_data  (byte_data)
);

@@ verif/tb_huffman_table_encoder_packer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_huffman_table_encoder_packer_unit
// Self-checking bench for the code table encoder and MSB-first byte packer.
// A directed sequence covers table loads, absent symbols, zero-length codes,
// full 15-bit codes, two-byte appends and flushes. A random phase then fills
// the table, encodes, reloads and flushes under bursty requests and a
// patterned stall on the byte port. A software copy of the table and the
// bit accumulator predicts every result byte. Each result is checked in order.
// ----------------------------------------------------------------------------
module tb_huffman_table_encoder_packer_unit;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_LEN      = 15;
  localparam int RAND_ITEMS   = 1320;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // Predicts the byte stream and checks results in order
  class packed_byte_checker;
    logic                        tbl_present [htep_pkg::TBL_DEPTH];
    logic [htep_pkg::LEN_W-1:0]  tbl_len     [htep_pkg::TBL_DEPTH];
    logic [htep_pkg::CODE_W-1:0] tbl_code    [htep_pkg::TBL_DEPTH];
    logic [6:0]                  pend_bits;
    int unsigned                 pend_cnt;
    htep_pkg::byte_res_t         expected_bytes[$];
    int                          err_count;

    function new();
      for (int i = 0; i < htep_pkg::TBL_DEPTH; i++) begin
        tbl_present[i] = 1'b0;
        tbl_len[i]     = '0;
        tbl_code[i]    = '0;
      end
      pend_bits = '0;
      pend_cnt  = 0;
      err_count = 0;
    endfunction

    task flag_mismatch(input string what);
      err_count++;
      $display("MISMATCH: %s", what);
    endtask

    // Append one prediction at the tail
    function void add_expected(input htep_pkg::byte_res_t res);
      expected_bytes = {expected_bytes, res};
    endfunction

    // Update the table or accumulator for one accepted request
    function void note_request(input htep_pkg::sym_req_t r);
      logic [31:0] acc;
      logic [31:0] mask;
      int unsigned len;
      int unsigned cnt;
      int          n;
      htep_pkg::byte_res_t res;
      n = 0;
      case (r.func)
        htep_pkg::FUNC_LOAD: begin
          tbl_present[r.symbol] = r.entry_present;
          tbl_len[r.symbol]     = (r.code_len > MAX_LEN) ?
                                  htep_pkg::LEN_W'(MAX_LEN) : r.code_len;
          tbl_code[r.symbol]    = r.code_bits;
        end
        htep_pkg::FUNC_ENCODE: begin
          if (!tbl_present[r.symbol]) begin
            res.out_byte    = '0;
            res.bits_used   = '0;
            res.status      = htep_pkg::STATUS_ABSENT;
            res.last_of_run = 1'b1;
            add_expected(res);
          end else if (tbl_len[r.symbol] != 0) begin
            len  = tbl_len[r.symbol];
            mask = (32'd1 << len) - 32'd1;
            acc  = ({25'd0, pend_bits} << len) | ({17'd0, tbl_code[r.symbol]} & mask);
            cnt  = pend_cnt + len;
            // peel off whole bytes, oldest bits first
            while (cnt >= 8) begin
              cnt -= 8;
              res.out_byte    = 8'(acc >> cnt);
              res.bits_used   = htep_pkg::USED_W'(8);
              res.status      = htep_pkg::STATUS_OK;
              res.last_of_run = 1'b0;
              add_expected(res);
              n++;
            end
            pend_bits = 7'(acc & ((32'd1 << cnt) - 32'd1));
            pend_cnt  = cnt;
            if (n > 0) begin
              expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
            end
          end
        end
        htep_pkg::FUNC_FLUSH: begin
          if (pend_cnt != 0) begin
            res.out_byte    = {1'b0, pend_bits};
            res.bits_used   = htep_pkg::USED_W'(pend_cnt);
            res.status      = htep_pkg::STATUS_OK;
            res.last_of_run = 1'b1;
            add_expected(res);
            pend_bits = '0;
            pend_cnt  = 0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result against the oldest prediction
    task check_byte(input htep_pkg::byte_res_t got);
      htep_pkg::byte_res_t want;
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte=%02h used=%0d status=%0d last=%0d",
                                got.out_byte, got.bits_used, got.status, got.last_of_run));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        flag_mismatch($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      if (got.bits_used !== want.bits_used)
        flag_mismatch($sformatf("bits_used got %0d want %0d", got.bits_used, want.bits_used));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last_of_run !== want.last_of_run)
        flag_mismatch($sformatf("last_of_run got %0d want %0d",
                                got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sym_valid = 1'b0;
  logic                sym_stall;
  htep_pkg::sym_req_t  sym_data = '0;
  logic                byte_valid;
  logic                byte_stall = 1'b0;
  htep_pkg::byte_res_t byte_data;

  packed_byte_checker sb;
  int cycle_count = 0;
  int burst_left  = 0;

  huffman_table_encoder_packer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_data  (sym_data),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data)
  );

  always #10 clk = ~clk;

  function automatic htep_pkg::sym_req_t mk_req(input logic [1:0] func,
                                                input logic [7:0] sym,
                                                input logic [14:0] code,
                                                input logic [3:0] len,
                                                input logic pres);
    htep_pkg::sym_req_t r;
    r.func          = func;
    r.symbol        = sym;
    r.code_bits     = code;
    r.code_len      = len;
    r.entry_present = pres;
    return r;
  endfunction

  // Mostly short codes, some long ones, a few zero-length
  function automatic logic [3:0] pick_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 4) return 4'd0;
    if (p < 70) return 4'($urandom_range(1, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic htep_pkg::sym_req_t rand_load(input logic [7:0] sym);
    return mk_req(htep_pkg::FUNC_LOAD, sym, 15'($urandom), pick_len(),
                  ($urandom_range(0, 99) < 92));
  endfunction

  function automatic htep_pkg::sym_req_t rand_fields(input logic [1:0] func);
    return mk_req(func, 8'($urandom), 15'($urandom), 4'($urandom), 1'($urandom));
  endfunction

  // Send one request in bursts with random gaps; returns once it is accepted
  task automatic send_request(input htep_pkg::sym_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        sym_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sym_valid <= 1'b1;
    sym_data  <= r;
    do @(posedge clk); while (sym_stall);
    sb.note_request(r);
  endtask

  // Byte port: sample results, stall on a changing pattern
  initial begin : byte_sink
    int seg_left;
    int mode;
    int phase;
    seg_left = 0;
    mode     = 0;
    phase    = 0;
    forever begin
      @(posedge clk);
      if (!rst && byte_valid && !byte_stall) sb.check_byte(byte_data);
      if (seg_left == 0) begin
        seg_left = $urandom_range(32, 200);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      phase++;
      case (mode)
        0: byte_stall <= 1'b0;
        1: byte_stall <= ($urandom_range(0, 3) == 0);
        2: byte_stall <= ($urandom_range(0, 3) != 0);
        default: byte_stall <= ((phase % 5) < 2);
      endcase
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    htep_pkg::sym_req_t req;
    int                 sent;
    int unsigned        pick;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, empty flush, unused func
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h55, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_FLUSH, 8'h00, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(FUNC_UNUSED, 8'hFF, 15'h7FFF, 4'hF, 1'b1));
    // full-length code, 1-bit code with junk above it, zero length, absent entry
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'h00, 15'h7FFF, 4'd15, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'hFF, 15'h7FFE, 4'd1, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'h0A, 15'h1234, 4'd0, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'h14, 15'h001F, 4'd5, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'h80, 15'h00A5, 4'd8, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h00, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'hFF, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h0A, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h14, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h00, 15'h0000, 4'd0, 1'b0));
    // 7 held + 15 new bits: two bytes from one request
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h00, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h80, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_FLUSH, 8'h00, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_FLUSH, 8'h00, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'hFF, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_FLUSH, 8'h00, 15'h0000, 4'd0, 1'b0));
    // all-zero long code
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'h00, 15'h0000, 4'd15, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h00, 15'h7FFF, 4'hF, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_ENCODE, 8'h80, 15'h0000, 4'd0, 1'b0));
    send_request(mk_req(htep_pkg::FUNC_FLUSH, 8'hFF, 15'h7FFF, 4'hF, 1'b1));
    send_request(mk_req(htep_pkg::FUNC_LOAD, 8'h00, 15'h0000, 4'd0, 1'b0));

    // Fill the whole table, then mostly encodes with reloads and flushes
    for (int s = 0; s < htep_pkg::TBL_DEPTH; s++) send_request(rand_load(8'(s)));
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) req = rand_fields(FUNC_UNUSED);
      else if (pick < 14) req = rand_load(8'($urandom));
      else if (pick < 24) req = rand_fields(htep_pkg::FUNC_FLUSH);
      else req = rand_fields(htep_pkg::FUNC_ENCODE);
      sent++;
      send_request(req);
    end
    sym_valid <= 1'b0;

    // Drain, then watch for stray results
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
